// ----- hdl/hamming74_stream_decoder_defines.svh -----
// assertion macros used by the checker file
`ifndef HAMMING74_STREAM_DECODER_DEFINES_SVH
`define HAMMING74_STREAM_DECODER_DEFINES_SVH

// a condition that must hold at every clock edge out of reset
`define H74SD_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("h74sd check failed");

// a condition that must hold in the cycle after a trigger
`define H74SD_ASSERT_NEXT(lbl, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("h74sd check failed");

`endif

// ----- hdl/h74sd_pkg.sv -----
package h74sd_pkg;

    localparam int CODEWORD_LEN = 7;
    localparam int FILL_W       = 3;
    localparam int BYTE_W       = 8;
    localparam int NIBBLE_W     = 4;
    // fill level at which one input byte completes two codewords
    localparam logic [FILL_W-1:0] FILL_TWO_CW = FILL_W'(CODEWORD_LEN - 1);

    // one input beat
    typedef struct packed {
        logic [BYTE_W-1:0] coded_byte;
        logic              end_of_stream;
    } h74sd_item_t;

    // one result beat
    typedef struct packed {
        logic [BYTE_W-1:0] decoded_byte;
        logic              byte_valid;
        logic              final_result;
    } h74sd_result_t;

    // correct a single bit error and pick data bits at positions 7, 6, 5, 3
    function automatic logic [NIBBLE_W-1:0] decode_nibble(
        input logic [CODEWORD_LEN-1:0] cw
    );
        logic [2:0]              syn;
        logic [CODEWORD_LEN-1:0] fixed;
        syn   = '0;
        fixed = cw;
        for (int i = 0; i < CODEWORD_LEN; i++)
        begin
            if (cw[i])
            begin
                syn = syn ^ 3'(i + 1);
            end
        end
        if (syn != 3'd0)
        begin
            fixed[syn - 3'd1] = ~cw[syn - 3'd1];
        end
        return {fixed[6], fixed[5], fixed[4], fixed[2]};
    endfunction

endpackage

// ----- hdl/h74sd_in_stage.sv -----
module h74sd_in_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  h74sd_pkg::h74sd_item_t in_item,
    input  logic                  take,
    output logic                  item_valid,
    output h74sd_pkg::h74sd_item_t item
);

    logic                   valid_reg;
    logic                   valid_next;
    h74sd_pkg::h74sd_item_t item_reg;

    // room when empty or when the held beat moves on this cycle
    assign in_ready   = !valid_reg || take;
    assign valid_next = in_valid ? 1'b1 : (valid_reg && !take);

    // input beat valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                valid_reg <= valid_next;
            end
        end
    end

    // input beat payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- hdl/h74sd_decode_core.sv -----
module h74sd_decode_core (
    input  logic                     clk,
    input  logic                     rst_n,
    input  h74sd_pkg::h74sd_item_t   item,
    input  logic                     take,
    output logic                     emit,
    output h74sd_pkg::h74sd_result_t result
);

    logic [h74sd_pkg::CODEWORD_LEN-1:0] bits_reg;
    logic [h74sd_pkg::CODEWORD_LEN-1:0] bits_next;
    logic [h74sd_pkg::FILL_W-1:0]       fill_reg;
    logic [h74sd_pkg::FILL_W-1:0]       fill_next;
    logic [h74sd_pkg::NIBBLE_W-1:0]     pend_reg;
    logic [h74sd_pkg::NIBBLE_W-1:0]     pend_next;
    logic                               wait_reg;
    logic                               wait_next;

    logic [h74sd_pkg::CODEWORD_LEN+h74sd_pkg::BYTE_W-1:0] joined;
    logic [h74sd_pkg::CODEWORD_LEN+h74sd_pkg::BYTE_W-1:0] shifted;
    logic [3:0]                         shamt;
    logic [h74sd_pkg::BYTE_W-1:0]       keep_mask;
    logic [h74sd_pkg::NIBBLE_W-1:0]     nib_first;
    logic [h74sd_pkg::NIBBLE_W-1:0]     nib_second;
    logic                               two_cw;
    logic                               have;
    logic [h74sd_pkg::BYTE_W-1:0]       byte_out;

    // align the first codeword that this byte completes
    assign joined     = {bits_reg, item.coded_byte};
    assign shamt      = {1'b0, fill_reg} + 4'd1;
    assign shifted    = joined >> shamt;
    assign keep_mask  = (h74sd_pkg::BYTE_W'(1) << shamt) - h74sd_pkg::BYTE_W'(1);
    assign two_cw     = (fill_reg == h74sd_pkg::FILL_TWO_CW);
    assign nib_first  = h74sd_pkg::decode_nibble(shifted[h74sd_pkg::CODEWORD_LEN-1:0]);
    assign nib_second = h74sd_pkg::decode_nibble(
                            item.coded_byte[h74sd_pkg::CODEWORD_LEN-1:0]);

    // nibble pairing and leftover bits
    always_comb
    begin
        have      = 1'b0;
        byte_out  = '0;
        pend_next = pend_reg;
        wait_next = wait_reg;
        if (wait_reg)
        begin
            have     = 1'b1;
            byte_out = {pend_reg, nib_first};
            if (two_cw)
            begin
                pend_next = nib_second;
                wait_next = 1'b1;
            end
            else
            begin
                pend_next = '0;
                wait_next = 1'b0;
            end
        end
        else
        begin
            if (two_cw)
            begin
                have      = 1'b1;
                byte_out  = {nib_first, nib_second};
                pend_next = '0;
                wait_next = 1'b0;
            end
            else
            begin
                pend_next = nib_first;
                wait_next = 1'b1;
            end
        end

        if (two_cw)
        begin
            bits_next = '0;
            fill_next = '0;
        end
        else
        begin
            bits_next = h74sd_pkg::CODEWORD_LEN'(item.coded_byte & keep_mask);
            fill_next = fill_reg + 3'd1;
        end

        // stream end drops leftovers
        if (item.end_of_stream)
        begin
            bits_next = '0;
            fill_next = '0;
            pend_next = '0;
            wait_next = 1'b0;
        end
    end

    // stream state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg <= '0;
            fill_reg <= '0;
            pend_reg <= '0;
            wait_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                bits_reg <= bits_next;
                fill_reg <= fill_next;
                pend_reg <= pend_next;
                wait_reg <= wait_next;
            end
        end
    end

    assign emit                = have || item.end_of_stream;
    assign result.decoded_byte = byte_out;
    assign result.byte_valid   = have;
    assign result.final_result = item.end_of_stream;

endmodule

// ----- hdl/hamming74_stream_decoder.sv -----
// channel   dir  handshake            beat contents
// in        in   in_valid/in_ready    coded_byte, end_of_stream
// out       out  out_valid/out_ready  decoded_byte, byte_valid, final_result
//
// one coded byte per clock sustained while the result side is not stalled; a beat
// reaches the result register via the input register, then decode into the result register
// the stream state advances only when the held input beat moves on
// rst_n clears the beat valid flags and the codeword and nibble state
// a stalled result holds the input register only for beats that make a result
module hamming74_stream_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] coded_byte,
    input  logic       end_of_stream,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] decoded_byte,
    output logic       byte_valid,
    output logic       final_result
);

    h74sd_pkg::h74sd_item_t   in_item;
    h74sd_pkg::h74sd_item_t   item;
    h74sd_pkg::h74sd_result_t result;
    h74sd_pkg::h74sd_result_t res_reg;
    logic                     item_valid;
    logic                     emit;
    logic                     take;
    logic                     out_valid_reg;
    logic                     out_valid_next;

    assign in_item.coded_byte    = coded_byte;
    assign in_item.end_of_stream = end_of_stream;

    h74sd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    h74sd_decode_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .take   (take),
        .emit   (emit),
        .result (result)
    );

    // held beat moves on when it makes no result or its result has a free slot
    assign take = item_valid && (!emit || !out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (take && emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    // result register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            res_reg <= result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign decoded_byte = res_reg.decoded_byte;
    assign byte_valid   = res_reg.byte_valid;
    assign final_result = res_reg.final_result;

endmodule

// ----- hdl/h74sd_checker.sv -----
`include "hamming74_stream_decoder_defines.svh"

module h74sd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] coded_byte,
    input logic       end_of_stream,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] decoded_byte,
    input logic       byte_valid,
    input logic       final_result
);

    // stalled result beat holds
    `H74SD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(decoded_byte) && $stable(byte_valid) && $stable(final_result))

    // a beat without a full byte only closes a stream
    `H74SD_ASSERT_ALWAYS(a_empty_is_final, !(out_valid && !byte_valid) || final_result)

    // a beat without a full byte carries zero data
    `H74SD_ASSERT_ALWAYS(a_empty_is_zero, !(out_valid && !byte_valid) || (decoded_byte == 8'd0))

    // with the result slot free the input is never blocked
    `H74SD_ASSERT_ALWAYS(a_free_ready, out_valid || in_ready)

endmodule

bind hamming74_stream_decoder h74sd_checker u_checker (.*);
